FILE: sv/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, sizes and codes of the retransmit timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

   // Table geometry and field widths.
   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 32;
   localparam int HANDLE_BITS = 16;
   localparam int CFG_BITS    = 4;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS    = $clog2(ENTRIES + 1);

   // Stream widths: key and handle travel in tdata, padded to whole bytes.
   localparam int DATA_BITS = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8;
   localparam int CMD_BITS  = 2;
   localparam int EV_BITS   = 3;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAIT_TICKS  = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [CFG_BITS-1:0] RETRY_RESET = 4'd2;
   localparam logic [CFG_BITS-1:0] WAIT_RESET  = 4'd3;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ACK  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

   // Event codes of the result beats.
   localparam logic [EV_BITS-1:0] EV_ADDED   = 3'd0;
   localparam logic [EV_BITS-1:0] EV_FULL    = 3'd1;
   localparam logic [EV_BITS-1:0] EV_ACKED   = 3'd2;
   localparam logic [EV_BITS-1:0] EV_UNKNOWN = 3'd3;
   localparam logic [EV_BITS-1:0] EV_RESEND  = 3'd4;
   localparam logic [EV_BITS-1:0] EV_GIVEUP  = 3'd5;
   localparam logic [EV_BITS-1:0] EV_TICKEND = 3'd6;

   // One table entry as stored in the RAM.
   typedef struct packed {
      logic [CFG_BITS-1:0]    retries;
      logic [CFG_BITS-1:0]    wait_cnt;
      logic [HANDLE_BITS-1:0] handle;
      logic [KEY_BITS-1:0]    key;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

FILE: sv/rtt_ram.sv
// ----------------------------------------------------------------------------
// rtt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is enabled.
// ----------------------------------------------------------------------------
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: sv/retransmit_timer_table_core.sv
// ----------------------------------------------------------------------------
// retransmit_timer_table_core
// Table of packets awaiting acknowledgment, kept oldest first in one RAM.
//
//   Channel  Direction  Handshake              Beat contents
//   req_     in         req_tvalid/req_tready  command, key, handle
//   rsp_     out        rsp_tvalid/rsp_tready  event, key, handle, last
//   csr_     in         csr_valid/csr_ready    register index, value
//
// An ack or a tick makes one pass over the stored entries at one entry per
// cycle through the RAM read port, while a tick's pass is not held. Entries
// behind a removed one are compacted toward the front during the same pass.
// A stalled result channel holds a tick's pass while a beat is waiting.
// Reset empties the table at once; the RAM itself is not cleared, since only
// entries below the count are read.
// ----------------------------------------------------------------------------
module retransmit_timer_table_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel. tdata: key, handle (then zero fill). tuser: command.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rtt_pkg::DATA_BITS-1:0]         req_tdata,
   input  logic [rtt_pkg::CMD_BITS-1:0]          req_tuser,
   // Result channel. tdata: key_res, handle_res (then zero fill).
   // tuser: event_res.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rtt_pkg::DATA_BITS-1:0]         rsp_tdata,
   output logic [rtt_pkg::EV_BITS-1:0]           rsp_tuser,
   output logic                                  rsp_tlast,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rtt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rtt_pkg::CFG_BITS-1:0]          csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Control state.
   state_type                          state_ff, state_in;
   logic [rtt_pkg::CNT_BITS-1:0]       count_ff, count_in;
   logic [rtt_pkg::CNT_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rtt_pkg::CNT_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic                               have_ff, have_in;
   logic                               found_ff, found_in;
   logic [rtt_pkg::CFG_BITS-1:0]       retry_limit_ff;
   logic [rtt_pkg::CFG_BITS-1:0]       wait_ticks_ff;

   // Latched command and the entry matched by an ack.
   logic [rtt_pkg::CMD_BITS-1:0]       cmd_ff, cmd_in;
   logic [rtt_pkg::KEY_BITS-1:0]       key_ff, key_in;
   logic [rtt_pkg::HANDLE_BITS-1:0]    handle_ff, handle_in;
   logic [rtt_pkg::HANDLE_BITS-1:0]    match_handle_ff, match_handle_in;

   // Output register.
   logic                               rsp_valid_ff;
   logic [rtt_pkg::EV_BITS-1:0]        rsp_event_ff;
   logic [rtt_pkg::KEY_BITS-1:0]       rsp_key_ff;
   logic [rtt_pkg::HANDLE_BITS-1:0]    rsp_handle_ff;
   logic                               rsp_last_ff;

   // Beat produced this cycle.
   logic                               emit;
   logic [rtt_pkg::EV_BITS-1:0]        emit_event;
   logic [rtt_pkg::KEY_BITS-1:0]       emit_key;
   logic [rtt_pkg::HANDLE_BITS-1:0]    emit_handle;
   logic                               emit_last;

   // RAM ports.
   logic                               ram_we;
   logic [rtt_pkg::IDX_BITS-1:0]       ram_waddr;
   rtt_pkg::entry_type                 ram_wdata;
   logic                               ram_re;
   rtt_pkg::entry_type                 ram_rdata;

   logic                               req_accept;
   logic                               out_free;
   logic                               is_tick;
   logic                               proceed;
   logic                               rd_more;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_tick    = (cmd_ff == rtt_pkg::CMD_TICK);
   assign rd_more    = (rd_ptr_ff < count_ff);
   // A tick may emit a beat for every entry, so it waits for a free slot.
   assign proceed    = !have_ff || !is_tick || out_free;

   rtt_ram #(
      .WIDTH (rtt_pkg::ENTRY_BITS),
      .DEPTH (rtt_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff[rtt_pkg::IDX_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   // Sequencer: add, scan pass for ack and tick, and the closing beat.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rd_ptr_in       = rd_ptr_ff;
      wr_ptr_in       = wr_ptr_ff;
      have_in         = have_ff;
      found_in        = found_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      handle_in       = handle_ff;
      match_handle_in = match_handle_ff;
      ram_we          = 1'b0;
      ram_waddr       = wr_ptr_ff[rtt_pkg::IDX_BITS-1:0];
      ram_wdata       = ram_rdata;
      ram_re          = 1'b0;
      emit            = 1'b0;
      emit_event      = rtt_pkg::EV_TICKEND;
      emit_key        = '0;
      emit_handle     = '0;
      emit_last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_tuser;
               key_in    = req_tdata[rtt_pkg::KEY_BITS-1:0];
               handle_in = req_tdata[rtt_pkg::KEY_BITS +: rtt_pkg::HANDLE_BITS];
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               have_in   = 1'b0;
               found_in  = 1'b0;
               unique case (req_tuser) inside
                  rtt_pkg::CMD_ADD:                    state_in = ST_ADD;
                  rtt_pkg::CMD_ACK, rtt_pkg::CMD_TICK: state_in = ST_SCAN;
                  default:                             state_in = ST_IDLE;
               endcase
            end
         end

         ST_ADD: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_key    = key_ff;
               emit_handle = handle_ff;
               if (count_ff == rtt_pkg::CNT_BITS'(rtt_pkg::ENTRIES)) begin
                  emit_event = rtt_pkg::EV_FULL;
               end else begin
                  emit_event         = rtt_pkg::EV_ADDED;
                  ram_we             = 1'b1;
                  ram_waddr          = count_ff[rtt_pkg::IDX_BITS-1:0];
                  ram_wdata.key      = key_ff;
                  ram_wdata.handle   = handle_ff;
                  ram_wdata.retries  = retry_limit_ff;
                  ram_wdata.wait_cnt = wait_ticks_ff;
                  count_in           = count_ff + rtt_pkg::CNT_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (proceed) begin
               // Work on the entry the RAM presented this cycle.
               if (have_ff) begin
                  if (is_tick) begin
                     if (ram_rdata.wait_cnt != '0) begin
                        ram_wdata.wait_cnt = ram_rdata.wait_cnt - rtt_pkg::CFG_BITS'(1);
                        ram_we             = 1'b1;
                        wr_ptr_in          = wr_ptr_ff + rtt_pkg::CNT_BITS'(1);
                     end else if (ram_rdata.retries != '0) begin
                        ram_wdata.retries  = ram_rdata.retries - rtt_pkg::CFG_BITS'(1);
                        ram_wdata.wait_cnt = wait_ticks_ff;
                        ram_we             = 1'b1;
                        wr_ptr_in          = wr_ptr_ff + rtt_pkg::CNT_BITS'(1);
                        emit               = 1'b1;
                        emit_event         = rtt_pkg::EV_RESEND;
                        emit_key           = ram_rdata.key;
                        emit_handle        = ram_rdata.handle;
                        emit_last          = 1'b0;
                     end else begin
                        emit        = 1'b1;
                        emit_event  = rtt_pkg::EV_GIVEUP;
                        emit_key    = ram_rdata.key;
                        emit_handle = ram_rdata.handle;
                        emit_last   = 1'b0;
                     end
                  end else if (!found_ff && (ram_rdata.key == key_ff)) begin
                     // Oldest matching entry is dropped from the table.
                     found_in        = 1'b1;
                     match_handle_in = ram_rdata.handle;
                  end else begin
                     ram_we    = 1'b1;
                     wr_ptr_in = wr_ptr_ff + rtt_pkg::CNT_BITS'(1);
                  end
               end
               // Fetch the next entry.
               if (rd_more) begin
                  ram_re    = 1'b1;
                  rd_ptr_in = rd_ptr_ff + rtt_pkg::CNT_BITS'(1);
                  have_in   = 1'b1;
               end else begin
                  have_in = 1'b0;
               end
            end
            if (!have_ff && !rd_more) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               count_in = wr_ptr_ff;
               state_in = ST_IDLE;
               if (!is_tick) begin
                  emit_key = key_ff;
                  if (found_ff) begin
                     emit_event  = rtt_pkg::EV_ACKED;
                     emit_handle = match_handle_ff;
                  end else begin
                     emit_event = rtt_pkg::EV_UNKNOWN;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         have_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         have_ff   <= have_in;
         found_ff  <= found_in;
      end
   end

   // Latched command fields.
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      handle_ff       <= handle_in;
      match_handle_ff <= match_handle_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= rtt_pkg::RETRY_RESET;
         wait_ticks_ff  <= rtt_pkg::WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rtt_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_data;
            rtt_pkg::CSR_WAIT_TICKS:  wait_ticks_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Output register; a beat is loaded only when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_event_ff  <= emit_event;
         rsp_key_ff    <= emit_key;
         rsp_handle_ff <= emit_handle;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rtt_pkg::DATA_BITS'({rsp_handle_ff, rsp_key_ff});

endmodule

FILE: sv/rtt_checker.sv
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the retransmit timer table, bound to the top level.
// ----------------------------------------------------------------------------
module rtt_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [rtt_pkg::DATA_BITS-1:0]         rsp_tdata,
   input  logic [rtt_pkg::EV_BITS-1:0]           rsp_tuser,
   input  logic                                  rsp_tlast
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // No result beat is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // Only per-entry tick events continue a run; every other event closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == ((rsp_tuser != rtt_pkg::EV_RESEND)
                                    && (rsp_tuser != rtt_pkg::EV_GIVEUP))))
      else $error("last flag does not match the event");

   // The tick-end beat carries neither key nor handle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rtt_pkg::EV_TICKEND) |-> (rsp_tdata == '0))
      else $error("tick end beat carries data");

endmodule

bind retransmit_timer_table_core rtt_checker u_rtt_checker (.*);

FILE: bench/retransmit_timer_table_core_test.sv
// ----------------------------------------------------------------------------
// retransmit_timer_table_core_test
// Self-checking bench for the retransmit timer table core.
//
// Commands are driven on the request stream with random gaps. A small
// scoreboard keeps its own copy of the table and predicts the burst of
// result beats that each accepted command causes. Every result beat is
// compared field by field with the oldest prediction. The run starts with
// directed corner cases and then goes through several register settings,
// each with its own command mix. The result stream is stalled at random.
// ----------------------------------------------------------------------------
module retransmit_timer_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 270;
   localparam int PHASE_ITEMS  = 45;
   localparam int MAX_GAP      = 17;
   localparam int DRAIN_CYCLES = 2 * rtt_pkg::ENTRIES + 8;
   localparam int CYCLE_LIMIT  = 600000;

   // One predicted or observed result beat.
   typedef struct {
      logic [rtt_pkg::EV_BITS-1:0]     code;
      logic [rtt_pkg::KEY_BITS-1:0]    key;
      logic [rtt_pkg::HANDLE_BITS-1:0] handle;
      logic                            last;
   } result_beat_type;

   // Scoreboard: a private copy of the table plus the queue of results
   // that are still owed by the block.
   class timer_table_scoreboard_type;
      rtt_pkg::entry_type           slots [rtt_pkg::ENTRIES];
      int                           fill;
      logic [rtt_pkg::CFG_BITS-1:0] retry_cfg;
      logic [rtt_pkg::CFG_BITS-1:0] wait_cfg;
      result_beat_type              expected_events [$];
      int unsigned                  errors;
      int unsigned                  beats_seen;
      int unsigned                  commands_seen;
      int unsigned                  code_seen [8];

      function new();
         retry_cfg     = rtt_pkg::RETRY_RESET;
         wait_cfg      = rtt_pkg::WAIT_RESET;
         fill          = 0;
         errors        = 0;
         beats_seen    = 0;
         commands_seen = 0;
         foreach (code_seen[i]) code_seen[i] = 0;
      endfunction

      function void note_config(logic [rtt_pkg::CSR_INDEX_BITS-1:0] index,
                                logic [rtt_pkg::CFG_BITS-1:0] value);
         if (index == rtt_pkg::CSR_RETRY_LIMIT) begin
            retry_cfg = value;
         end else begin
            wait_cfg = value;
         end
      endfunction

      function void add_expected(logic [rtt_pkg::EV_BITS-1:0] code,
                                 logic [rtt_pkg::KEY_BITS-1:0] key,
                                 logic [rtt_pkg::HANDLE_BITS-1:0] handle);
         result_beat_type beat;
         beat.code   = code;
         beat.key    = key;
         beat.handle = handle;
         beat.last   = 1'b0;
         expected_events.push_back(beat);
      endfunction

      // Apply one accepted command to the table copy and queue its results.
      function void note_command(logic [rtt_pkg::CMD_BITS-1:0] cmd,
                                 logic [rtt_pkg::KEY_BITS-1:0] key,
                                 logic [rtt_pkg::HANDLE_BITS-1:0] handle);
         int   hit;
         int   keep;
         logic kept;
         case (cmd)
            rtt_pkg::CMD_ADD: begin
               if (fill >= rtt_pkg::ENTRIES) begin
                  add_expected(rtt_pkg::EV_FULL, key, handle);
               end else begin
                  slots[fill].key      = key;
                  slots[fill].handle   = handle;
                  slots[fill].retries  = retry_cfg;
                  slots[fill].wait_cnt = wait_cfg;
                  fill++;
                  add_expected(rtt_pkg::EV_ADDED, key, handle);
               end
            end
            rtt_pkg::CMD_ACK: begin
               // The oldest entry with a matching key wins.
               hit = fill;
               for (int i = 0; i < fill; i++) begin
                  if (hit == fill && slots[i].key == key) hit = i;
               end
               if (hit < fill) begin
                  add_expected(rtt_pkg::EV_ACKED, slots[hit].key, slots[hit].handle);
                  for (int i = hit; i + 1 < fill; i++) slots[i] = slots[i + 1];
                  fill--;
               end else begin
                  add_expected(rtt_pkg::EV_UNKNOWN, key, '0);
               end
            end
            rtt_pkg::CMD_TICK: begin
               // Age every entry, oldest first, compacting out the given-up ones.
               keep = 0;
               for (int i = 0; i < fill; i++) begin
                  kept = 1'b1;
                  if (slots[i].wait_cnt != 0) begin
                     slots[i].wait_cnt = slots[i].wait_cnt - 1'b1;
                  end else if (slots[i].retries != 0) begin
                     slots[i].retries  = slots[i].retries - 1'b1;
                     slots[i].wait_cnt = wait_cfg;
                     add_expected(rtt_pkg::EV_RESEND, slots[i].key, slots[i].handle);
                  end else begin
                     add_expected(rtt_pkg::EV_GIVEUP, slots[i].key, slots[i].handle);
                     kept = 1'b0;
                  end
                  if (kept) begin
                     slots[keep] = slots[i];
                     keep++;
                  end
               end
               fill = keep;
               add_expected(rtt_pkg::EV_TICKEND, '0, '0);
            end
            default: begin
               // The unused command code leaves everything as it was.
               return;
            end
         endcase
         expected_events[expected_events.size() - 1].last = 1'b1;
         commands_seen++;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      // Compare one accepted result beat with the oldest prediction.
      function void check_event(logic [rtt_pkg::EV_BITS-1:0] code,
                                logic [rtt_pkg::KEY_BITS-1:0] key,
                                logic [rtt_pkg::HANDLE_BITS-1:0] handle, logic last);
         result_beat_type want;
         beats_seen++;
         if (!$isunknown(code)) code_seen[code]++;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual code %0d key %h",
                     $time, code, key);
            $display("   handle %h last %b", handle, last);
            return;
         end
         want = expected_events.pop_front();
         compare_field("event code", 64'(want.code), 64'(code));
         compare_field("key", 64'(want.key), 64'(key));
         compare_field("handle", 64'(want.handle), 64'(handle));
         compare_field("last flag", 64'(want.last), 64'(last));
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function int occupancy();
         return fill;
      endfunction

      function logic [rtt_pkg::KEY_BITS-1:0] key_at(int index);
         return slots[index].key;
      endfunction
   endclass

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [rtt_pkg::DATA_BITS-1:0]      req_tdata  = '0;
   logic [rtt_pkg::CMD_BITS-1:0]       req_tuser  = rtt_pkg::CMD_NONE;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [rtt_pkg::DATA_BITS-1:0]      rsp_tdata;
   logic [rtt_pkg::EV_BITS-1:0]        rsp_tuser;
   logic                               rsp_tlast;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [rtt_pkg::CSR_INDEX_BITS-1:0] csr_index  = rtt_pkg::CSR_RETRY_LIMIT;
   logic [rtt_pkg::CFG_BITS-1:0]       csr_data   = '0;

   // Set during stretches in which neither side idles.
   logic                      calm       = 1'b0;
   int unsigned               cycle_count = 0;
   int unsigned               config_writes = 0;

   timer_table_scoreboard_type table_sb = new();

   retransmit_timer_table_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // key, handle, zero fill
      .req_tuser  (req_tuser),   // command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // key_res, handle_res, zero fill
      .rsp_tuser  (rsp_tuser),   // event_res
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock.
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Result monitor and run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset && rsp_tready && rsp_tvalid !== 1'b0) begin
         table_sb.check_event(rsp_tuser, rsp_tdata[rtt_pkg::KEY_BITS-1:0],
                              rsp_tdata[rtt_pkg::KEY_BITS +: rtt_pkg::HANDLE_BITS],
                              rsp_tlast);
      end
   end

   // Result stream back-pressure: a random stall before each beat.
   initial begin : result_stall
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Drive one command beat after a random gap and record it once accepted.
   task automatic send_command(logic [rtt_pkg::CMD_BITS-1:0] cmd,
                               logic [rtt_pkg::KEY_BITS-1:0] key,
                               logic [rtt_pkg::HANDLE_BITS-1:0] handle);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= rtt_pkg::DATA_BITS'({handle, key});
      do @(posedge clock); while (req_tready !== 1'b1);
      table_sb.note_command(cmd, key, handle);
   endtask

   // Stop sending, wait for every owed result, then let the pipeline empty.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (table_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers; valid stays high across the two beats.
   task automatic configure(logic [rtt_pkg::CFG_BITS-1:0] retry_value,
                            logic [rtt_pkg::CFG_BITS-1:0] wait_value);
      csr_valid <= 1'b1;
      csr_index <= rtt_pkg::CSR_RETRY_LIMIT;
      csr_data  <= retry_value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      table_sb.note_config(rtt_pkg::CSR_RETRY_LIMIT, retry_value);
      csr_index <= rtt_pkg::CSR_WAIT_TICKS;
      csr_data  <= wait_value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      table_sb.note_config(rtt_pkg::CSR_WAIT_TICKS, wait_value);
      csr_valid <= 1'b0;
      config_writes += 2;
   endtask

   // Main sequence.
   initial begin : stimulus
      int unsigned                     counted;
      int unsigned                     phase_count;
      int unsigned                     phase;
      int unsigned                     pick;
      int unsigned                     add_pct;
      int unsigned                     ack_pct;
      logic [rtt_pkg::CMD_BITS-1:0]    cmd;
      logic [rtt_pkg::KEY_BITS-1:0]    key;
      logic [rtt_pkg::HANDLE_BITS-1:0] handle;
      logic [rtt_pkg::CFG_BITS-1:0]    retry_value;
      logic [rtt_pkg::CFG_BITS-1:0]    wait_value;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty table: a tick gives only its end marker, the unused code is
      // ignored and any ack is unknown.
      send_command(rtt_pkg::CMD_TICK, '0, '0);
      send_command(rtt_pkg::CMD_NONE, '1, '1);
      send_command(rtt_pkg::CMD_ACK, '1, '0);

      // Key and handle extremes, a duplicate key, and an ack that must take
      // the oldest of the two duplicates.
      send_command(rtt_pkg::CMD_ADD, '0, '0);
      send_command(rtt_pkg::CMD_ADD, '1, '1);
      send_command(rtt_pkg::CMD_ADD, '0, 16'h1234);
      send_command(rtt_pkg::CMD_ACK, '0, '1);
      send_command(rtt_pkg::CMD_ACK, 32'h5555_aaaa, 16'haaaa);

      // With the reset wait of three, the fourth tick causes resends.
      repeat (4) send_command(rtt_pkg::CMD_TICK, 32'h0f0f_0f0f, 16'hf0f0);

      // No retries and no wait: a fresh entry is given up at the next tick.
      settle_idle();
      configure('0, '0);
      send_command(rtt_pkg::CMD_ADD, 32'h8000_0001, 16'h8001);
      send_command(rtt_pkg::CMD_TICK, '0, '0);
      send_command(rtt_pkg::CMD_TICK, '0, '0);
      send_command(rtt_pkg::CMD_TICK, '0, '0);
      send_command(rtt_pkg::CMD_TICK, '0, '0);

      // Random phases, each with its own settings and command mix.
      counted = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         settle_idle();
         case (phase)
            0: begin
               retry_value = '1;
               wait_value  = '1;
            end
            1: begin
               retry_value = '0;
               wait_value  = '0;
            end
            default: begin
               retry_value = rtt_pkg::CFG_BITS'($urandom_range(0, 15));
               wait_value  = rtt_pkg::CFG_BITS'($urandom_range(0, 15));
            end
         endcase
         configure(retry_value, wait_value);

         // Mixes: filling the table, a balanced load, and mostly aging.
         case (phase % 3)
            0: begin
               add_pct = 70;
               ack_pct = 10;
            end
            1: begin
               add_pct = 40;
               ack_pct = 30;
            end
            default: begin
               add_pct = 25;
               ack_pct = 15;
            end
         endcase

         phase_count = 0;
         while (phase_count < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
            if (counted % 15 == 0) calm = ($urandom_range(0, 3) == 0);
            key    = $urandom;
            handle = rtt_pkg::HANDLE_BITS'($urandom);
            pick   = $urandom_range(0, 99);
            if (pick < 4) begin
               cmd = rtt_pkg::CMD_NONE;
            end else if (pick < 4 + add_pct) begin
               cmd = rtt_pkg::CMD_ADD;
               if (table_sb.occupancy() > 0 && $urandom_range(0, 6) == 0) begin
                  key = table_sb.key_at($urandom_range(0, table_sb.occupancy() - 1));
               end
            end else if (pick < 4 + add_pct + ack_pct) begin
               cmd = rtt_pkg::CMD_ACK;
               if (table_sb.occupancy() > 0 && $urandom_range(0, 3) != 0) begin
                  key = table_sb.key_at($urandom_range(0, table_sb.occupancy() - 1));
               end
            end else begin
               cmd = rtt_pkg::CMD_TICK;
            end
            send_command(cmd, key, handle);
            if (cmd != rtt_pkg::CMD_NONE) begin
               counted++;
               phase_count++;
            end
         end
         phase++;
      end

      calm = 1'b0;
      settle_idle();

      $display("Ran %0d commands over %0d settings and checked %0d result beats.",
               table_sb.commands_seen, phase + 2, table_sb.beats_seen);
      $display("Seen: %0d full, %0d acked, %0d resends, %0d give-ups, %0d tick ends.",
               table_sb.code_seen[rtt_pkg::EV_FULL], table_sb.code_seen[rtt_pkg::EV_ACKED],
               table_sb.code_seen[rtt_pkg::EV_RESEND],
               table_sb.code_seen[rtt_pkg::EV_GIVEUP],
               table_sb.code_seen[rtt_pkg::EV_TICKEND]);
      if (table_sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
